FILE: rtl/core/kme_pkg.sv
// ----------------------------------------------------------------------------
// kme_pkg
// Types, sizes and the key map shared by the keypad key emulator.
// ----------------------------------------------------------------------------
package kme_pkg;

	localparam int FIFO_DEPTH = 16;
	localparam int ROW_COUNT  = 4;
	localparam int COL_COUNT  = 3;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = (PTR_W + 1 > 4) ? PTR_W + 1 : 4;
	localparam int ROW_W      = $clog2(ROW_COUNT);
	localparam int COL_W      = 2;

	localparam logic OP_POLL  = 1'b0;
	localparam logic OP_QUEUE = 1'b1;

	localparam logic [15:0] PRESS_TICKS_RESET = 16'd100;
	localparam logic [15:0] HOLD_COUNT_MAX    = 16'hFFFF;

	typedef struct packed {
		logic       opcode;
		logic [7:0] key_char;
		logic [3:0] row_levels;
		logic       ms_tick;
	} kme_in_t;

	typedef struct packed {
		logic [2:0] col_drive;
		logic       idle;
		logic       dropped;
		logic       rejected;
		logic [3:0] queue_count;
	} kme_out_t;

	typedef struct packed {
		logic             ok;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} kme_key_t;

	// Keys 1..9 in reading order, then C, 0, R on the bottom row.
	function automatic kme_key_t map_key(input logic [7:0] ch);
		kme_key_t k;
		k = '{ok: 1'b1, row: '0, col: '0};
		case (ch)
			8'h31: begin k.row = 2'd0; k.col = 2'd0; end
			8'h32: begin k.row = 2'd0; k.col = 2'd1; end
			8'h33: begin k.row = 2'd0; k.col = 2'd2; end
			8'h34: begin k.row = 2'd1; k.col = 2'd0; end
			8'h35: begin k.row = 2'd1; k.col = 2'd1; end
			8'h36: begin k.row = 2'd1; k.col = 2'd2; end
			8'h37: begin k.row = 2'd2; k.col = 2'd0; end
			8'h38: begin k.row = 2'd2; k.col = 2'd1; end
			8'h39: begin k.row = 2'd2; k.col = 2'd2; end
			8'h43, 8'h63: begin k.row = 2'd3; k.col = 2'd0; end
			8'h30: begin k.row = 2'd3; k.col = 2'd1; end
			8'h52, 8'h72: begin k.row = 2'd3; k.col = 2'd2; end
			default: k.ok = 1'b0;
		endcase
		return k;
	endfunction

endpackage

FILE: rtl/core/keypad_matrix_key_emulator.sv
// ----------------------------------------------------------------------------
// keypad_matrix_key_emulator
// Emulates presses on a 4x3 matrix keypad scanned by an external controller.
// ----------------------------------------------------------------------------
// Each input beat is either a queue beat (put a key character into the ring
// FIFO, which holds FIFO_DEPTH-1 keys and flags a drop when full) or a poll
// beat (dequeue a key when idle, latch it once its row line is sampled low,
// then pull its column low for press_ticks millisecond ticks). Every input
// beat produces exactly one result beat that shows the state after it. The
// block takes one beat per cycle: the whole update is one pass of logic from
// the state registers and the input beat into a two-entry result buffer, so
// the sustained rate is one beat per clock. The input stalls only when both
// result entries are full, which takes a downstream stall. The key FIFO
// lives in flip-flops and is read at the read pointer in the same cycle.
// Write press_ticks only while no beat is in flight; a held key compares
// against the new value from the next poll on. cfg_ready is always high.
module keypad_matrix_key_emulator (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  kme_pkg::kme_in_t in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output kme_pkg::kme_out_t out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [15:0]      cfg_data
);
	import kme_pkg::*;

	// Key store and press state.
	logic [7:0]       fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic             awaiting_q, holding_q;
	logic [ROW_W-1:0] active_row_q;
	logic [COL_W-1:0] active_col_q;
	logic [15:0]      hold_count_q;
	logic [15:0]      press_ticks_q;

	// Two-entry result buffer: entry 0 is the head shown on the output.
	kme_out_t res_q [2];
	logic [1:0] res_cnt_q;

	logic push, pop;
	logic res_to_head;

	// Next state from one pass.
	logic [PTR_W-1:0] wr_ptr_d, rd_ptr_d, wr_next, rd_next;
	logic             awaiting_d, holding_d;
	logic [ROW_W-1:0] active_row_d;
	logic [COL_W-1:0] active_col_d;
	logic [15:0]      hold_count_d;
	logic             fifo_we;
	logic             dropped, rejected;
	logic [CNT_W-1:0] count_cur, count_new;
	kme_key_t         key;
	kme_out_t         res;

	function automatic logic [CNT_W-1:0] fill(input logic [PTR_W-1:0] wp,
			input logic [PTR_W-1:0] rp);
		logic [CNT_W-1:0] diff;
		diff = CNT_W'(wp) - CNT_W'(rp);
		if (wp < rp) begin
			diff = diff + CNT_W'(FIFO_DEPTH);
		end
		return diff;
	endfunction

	assign cfg_ready = 1'b1;

	assign out_valid = (res_cnt_q != 2'd0);
	assign out_data  = res_q[0];
	assign pop       = out_valid && !out_stall;
	assign in_stall  = (res_cnt_q == 2'd2);
	assign push      = in_valid && !in_stall;

	assign wr_next   = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
	assign rd_next   = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
	assign count_cur = fill(wr_ptr_q, rd_ptr_q);
	assign key       = map_key(fifo_q[rd_ptr_q]);

	always_comb begin
		wr_ptr_d     = wr_ptr_q;
		rd_ptr_d     = rd_ptr_q;
		awaiting_d   = awaiting_q;
		holding_d    = holding_q;
		active_row_d = active_row_q;
		active_col_d = active_col_q;
		hold_count_d = hold_count_q;
		fifo_we      = 1'b0;
		dropped      = 1'b0;
		rejected     = 1'b0;

		if (in_data.opcode == OP_QUEUE) begin
			// Keep one slot free: full when the next write would meet the reader.
			if (wr_next != rd_ptr_q) begin
				fifo_we  = 1'b1;
				wr_ptr_d = wr_next;
			end else begin
				dropped = 1'b1;
			end
		end else begin
			// Dequeue and decode when nothing is in flight.
			if (!awaiting_q && !holding_q && count_cur != '0) begin
				rd_ptr_d = rd_next;
				if (key.ok) begin
					active_row_d = key.row;
					active_col_d = key.col;
					awaiting_d   = 1'b1;
				end else begin
					rejected = 1'b1;
				end
			end
			// Latch on a low row line, even for a key dequeued in this poll.
			if (awaiting_d) begin
				if (!in_data.row_levels[active_row_d]) begin
					awaiting_d   = 1'b0;
					holding_d    = 1'b1;
					hold_count_d = '0;
				end
			end else if (holding_q) begin
				if (in_data.ms_tick && hold_count_q != HOLD_COUNT_MAX) begin
					hold_count_d = hold_count_q + 16'd1;
				end
				if (hold_count_d >= press_ticks_q) begin
					holding_d = 1'b0;
				end
			end
		end

		count_new       = fill(wr_ptr_d, rd_ptr_d);
		res.col_drive   = holding_d ? 3'(3'b001 << active_col_d) : 3'b000;
		res.idle        = !awaiting_d && !holding_d && (count_new == '0);
		res.dropped     = dropped;
		res.rejected    = rejected;
		res.queue_count = count_new[3:0];
	end

	// Commit state on an accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q      <= '0;
			rd_ptr_q      <= '0;
			awaiting_q    <= 1'b0;
			holding_q     <= 1'b0;
			active_row_q  <= '0;
			active_col_q  <= '0;
			hold_count_q  <= '0;
			press_ticks_q <= PRESS_TICKS_RESET;
		end else begin
			if (push) begin
				wr_ptr_q     <= wr_ptr_d;
				rd_ptr_q     <= rd_ptr_d;
				awaiting_q   <= awaiting_d;
				holding_q    <= holding_d;
				active_row_q <= active_row_d;
				active_col_q <= active_col_d;
				hold_count_q <= hold_count_d;
			end
			if (cfg_valid && cfg_ready) begin
				press_ticks_q <= cfg_data;
			end
		end
	end

	// Key store: write only, no reset.
	always_ff @(posedge clk) begin
		if (push && fifo_we) begin
			fifo_q[wr_ptr_q] <= in_data.key_char;
		end
	end

	// Result buffer: shift on a pop, write the new beat behind what stays.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= 2'd0;
		end else begin
			res_cnt_q <= res_cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// The new beat lands in the head when the buffer is empty or drains to empty.
	assign res_to_head = push && (res_cnt_q == 2'd0 || (res_cnt_q == 2'd1 && pop));

	always_ff @(posedge clk) begin
		if (res_to_head) begin
			res_q[0] <= res;
		end else if (pop) begin
			res_q[0] <= res_q[1];
		end
		if (push && !res_to_head) begin
			res_q[1] <= res;
		end
	end

endmodule
